FILE: rtl/mtef_pkg.sv
// Shared types and constants for the MIDI track event framer.
// No dependencies; the front end, frame queue, serializer and top level import this package.
package mtef_pkg;

	// Channel tracks kept by the block
	localparam int CHANNELS = 16;
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Field widths fixed by the stream format
	localparam int TIME_W = 32;
	localparam int COUNT_W = 32;
	localparam int BYTE_W = 8;
	localparam int CHAN_W = 4;
	localparam int LEN_W = 2;
	localparam int TPA_W = 8;
	localparam int MASK_W = 16;

	// Variable-length quantity: 7 payload bits per byte, up to 5 bytes
	localparam int VLQ_N_W = 3;
	localparam int IDX_W = 4;

	// Frame queue between front and back
	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RECORD_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_ATOM = 2'd2;
	localparam logic [TPA_W-1:0] TPA_RESET = 8'd80;

	typedef struct packed {
		logic record_enable;
		logic [MASK_W-1:0] channel_enable_mask;
		logic [TPA_W-1:0] ticks_per_atom;
	} cfg_t;

	// One classified event waiting to be serialized
	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [TIME_W-1:0] delta;
		logic [BYTE_W-1:0] status;
		logic [BYTE_W-1:0] data_one;
		logic [BYTE_W-1:0] data_two;
		logic [LEN_W-1:0] len;
	} frame_t;

	// One output word
	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [BYTE_W-1:0] data;
		logic [COUNT_W-1:0] count;
		logic last;
	} result_t;

endpackage

FILE: rtl/mtef_front.sv
// Front end: accepts events, drops those not recorded, keeps per-channel last
// event time and forms the scaled delta. Depends on mtef_pkg.
module mtef_front (
	input  logic clk,
	input  logic arst_n,
	input  mtef_pkg::cfg_t cfg,
	input  logic push,
	output logic full,
	input  logic [mtef_pkg::TIME_W-1:0] atom_time,
	input  logic [mtef_pkg::BYTE_W-1:0] status_byte,
	input  logic [mtef_pkg::BYTE_W-1:0] data_one,
	input  logic [mtef_pkg::BYTE_W-1:0] data_two,
	input  logic [mtef_pkg::LEN_W-1:0] event_length,
	input  logic to_file,
	output logic frame_valid,
	output mtef_pkg::frame_t frame,
	input  logic frame_ready
);
	import mtef_pkg::*;

	logic [TIME_W-1:0] last_time_q [CHANNELS];
	logic [CHAN_W-1:0] ch;
	logic [CH_W-1:0] chi;
	logic emit;
	logic accept;
	logic s1_ready;
	logic s2_ready;

	logic valid_s1;
	logic [TIME_W-1:0] diff_s1;
	logic [CHAN_W-1:0] ch_s1;
	logic [BYTE_W-1:0] status_s1;
	logic [BYTE_W-1:0] d1_s1;
	logic [BYTE_W-1:0] d2_s1;
	logic [LEN_W-1:0] len_s1;

	logic valid_s2;
	frame_t frame_s2;

	// Classify the incoming event
	assign ch = status_byte[CHAN_W-1:0];
	assign chi = ch[CH_W-1:0];
	assign emit = cfg.record_enable && to_file && (32'(ch) < CHANNELS)
		&& cfg.channel_enable_mask[ch];

	// Stage handshake: a stage moves when the one after it has room
	assign s2_ready = !valid_s2 || frame_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign full = !s1_ready;
	assign accept = push && s1_ready;

	// Track the time of the last recorded event per channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_time_q[i] <= '0;
			end
		end else if (accept && emit) begin
			last_time_q[chi] <= atom_time;
		end
	end

	// Stage valid bits; dropped events never enter the pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= accept && emit;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: time difference, stage 2: scale by ticks per atom
	always_ff @(posedge clk) begin
		if (s1_ready && accept && emit) begin
			diff_s1 <= atom_time - last_time_q[chi];
			ch_s1 <= ch;
			status_s1 <= status_byte;
			d1_s1 <= data_one;
			d2_s1 <= data_two;
			len_s1 <= event_length;
		end
		if (s2_ready && valid_s1) begin
			frame_s2.channel <= ch_s1;
			frame_s2.delta <= TIME_W'(diff_s1 * cfg.ticks_per_atom);
			frame_s2.status <= status_s1;
			frame_s2.data_one <= d1_s1;
			frame_s2.data_two <= d2_s1;
			frame_s2.len <= len_s1;
		end
	end

	assign frame_valid = valid_s2;
	assign frame = frame_s2;

endmodule

FILE: rtl/mtef_frame_q.sv
// Short frame queue that decouples the front end from the serializer.
// Depends on mtef_pkg.
module mtef_frame_q (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  mtef_pkg::frame_t wr_frame,
	output logic rd_valid,
	input  logic rd_pop,
	output mtef_pkg::frame_t rd_frame
);
	import mtef_pkg::*;

	frame_t mem_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wp_q;
	logic [FQ_PTR_W-1:0] rp_q;
	logic [FQ_CNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = cnt_q != FQ_CNT_W'(FQ_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_pop && rd_valid;
	assign rd_frame = mem_q[rp_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_frame;
		end
	end

endmodule

FILE: rtl/mtef_back.sv
// Back end: serializes each frame into delta-time bytes and event bytes,
// counts track bytes per channel and buffers words. Depends on mtef_pkg.
module mtef_back (
	input  logic clk,
	input  logic arst_n,
	input  logic frame_valid,
	input  mtef_pkg::frame_t frame,
	output logic frame_pop,
	output logic empty,
	input  logic pop,
	output mtef_pkg::result_t result
);
	import mtef_pkg::*;

	// Number of bytes in the minimal encoding of a 32-bit value
	function automatic logic [VLQ_N_W-1:0] vlq_len(input logic [TIME_W-1:0] v);
		logic [VLQ_N_W-1:0] n;
		priority if (v[31:28] != '0) n = 3'd5;
		else if (v[27:21] != '0) n = 3'd4;
		else if (v[20:14] != '0) n = 3'd3;
		else if (v[13:7] != '0) n = 3'd2;
		else n = 3'd1;
		return n;
	endfunction

	logic [COUNT_W-1:0] count_q [CHANNELS];
	logic cur_valid_q;
	frame_t cur_q;
	logic [VLQ_N_W-1:0] nv_q;
	logic [IDX_W-1:0] tot_q;
	logic [IDX_W-1:0] k_q;

	result_t slot0_q;
	result_t slot1_q;
	logic [1:0] oc_q;

	logic [VLQ_N_W-1:0] head_nv;
	logic [CH_W-1:0] chi;
	logic [IDX_W-1:0] nv_ext;
	logic in_delta;
	logic [VLQ_N_W-1:0] grp;
	logic [IDX_W-1:0] ev_idx;
	logic [6:0] g7;
	logic [BYTE_W-1:0] cur_byte;
	logic is_last;
	logic pop_acc;
	logic out_space;
	logic emit;
	logic ld;
	result_t nxt;

	// Pick the current byte
	assign head_nv = vlq_len(frame.delta);
	assign chi = cur_q.channel[CH_W-1:0];
	assign nv_ext = {1'b0, nv_q};
	assign in_delta = k_q < nv_ext;
	assign grp = VLQ_N_W'(nv_ext - 4'd1 - k_q);
	assign ev_idx = k_q - nv_ext;
	assign is_last = k_q == tot_q - 4'd1;

	always_comb begin
		unique case (grp)
			3'd0: g7 = cur_q.delta[6:0];
			3'd1: g7 = cur_q.delta[13:7];
			3'd2: g7 = cur_q.delta[20:14];
			3'd3: g7 = cur_q.delta[27:21];
			3'd4: g7 = {3'b000, cur_q.delta[31:28]};
			default: g7 = '0;
		endcase
		if (in_delta) begin
			cur_byte = {k_q != nv_ext - 4'd1, g7};
		end else begin
			unique case (ev_idx[1:0])
				2'd0: cur_byte = cur_q.status;
				2'd1: cur_byte = cur_q.data_one;
				default: cur_byte = cur_q.data_two;
			endcase
		end
	end

	// Handshake between serializer and output buffer
	assign pop_acc = pop && (oc_q != 2'd0);
	assign out_space = (oc_q != 2'd2) || pop_acc;
	assign emit = cur_valid_q && out_space;
	assign ld = frame_valid && (!cur_valid_q || (emit && is_last));
	assign frame_pop = ld;

	assign nxt.channel = cur_q.channel;
	assign nxt.data = cur_byte;
	assign nxt.count = count_q[chi] + 1'b1;
	assign nxt.last = is_last;

	// Step through the bytes of the current frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			k_q <= '0;
		end else if (ld) begin
			cur_valid_q <= 1'b1;
			k_q <= '0;
		end else if (emit && is_last) begin
			cur_valid_q <= 1'b0;
		end else if (emit) begin
			k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			cur_q <= frame;
			nv_q <= head_nv;
			tot_q <= IDX_W'(head_nv) + IDX_W'(frame.len);
		end
	end

	// Advance the per-channel byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				count_q[i] <= '0;
			end
		end else if (emit) begin
			count_q[chi] <= nxt.count;
		end
	end

	// Two-word output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q <= '0;
		end else if (emit && !pop_acc) begin
			oc_q <= oc_q + 1'b1;
		end else if (pop_acc && !emit) begin
			oc_q <= oc_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !pop_acc) begin
			if (oc_q == 2'd0) begin
				slot0_q <= nxt;
			end else begin
				slot1_q <= nxt;
			end
		end else if (pop_acc && !emit) begin
			slot0_q <= slot1_q;
		end else if (pop_acc && emit) begin
			if (oc_q == 2'd1) begin
				slot0_q <= nxt;
			end else begin
				slot0_q <= slot1_q;
				slot1_q <= nxt;
			end
		end
	end

	assign empty = oc_q == 2'd0;
	assign result = slot0_q;

endmodule

FILE: rtl/midi_track_event_framer_top.sv
// Top level of the MIDI track event framer: configuration registers and the
// front end, frame queue and serializer. Depends on mtef_pkg and its modules.
//
// Each accepted event whose channel is recorded becomes a track event: the
// delta time (time difference times ticks per atom) as a minimal 1 to 5 byte
// variable-length quantity, then 0 to 3 event bytes, one word per cycle on the
// result side while the two-word output buffer has room, so an event gives
// 1 to 8 words. The front end takes one event per cycle while the four-frame
// queue has room and passes it through two stages (difference, multiply);
// events that are not recorded are accepted and dropped at once.
// Write configuration only while the block is idle.
module midi_track_event_framer_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mtef_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mtef_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic push,
	output logic full,
	input  logic [mtef_pkg::TIME_W-1:0] atom_time,
	input  logic [mtef_pkg::BYTE_W-1:0] status_byte,
	input  logic [mtef_pkg::BYTE_W-1:0] data_one,
	input  logic [mtef_pkg::BYTE_W-1:0] data_two,
	input  logic [mtef_pkg::LEN_W-1:0] event_length,
	input  logic to_file,
	output logic empty,
	input  logic pop,
	output logic [mtef_pkg::CHAN_W-1:0] out_channel,
	output logic [mtef_pkg::BYTE_W-1:0] out_byte,
	output logic [mtef_pkg::COUNT_W-1:0] track_count,
	output logic last_byte
);
	import mtef_pkg::*;

	cfg_t cfg_q;
	logic fr_valid;
	logic fr_ready;
	frame_t fr_frame;
	logic hd_valid;
	logic hd_pop;
	frame_t hd_frame;
	result_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.record_enable <= 1'b0;
			cfg_q.channel_enable_mask <= '0;
			cfg_q.ticks_per_atom <= TPA_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RECORD_ENABLE: cfg_q.record_enable <= cfg_wdata[0];
				CFG_CHANNEL_MASK: cfg_q.channel_enable_mask <= cfg_wdata[MASK_W-1:0];
				CFG_TICKS_PER_ATOM: cfg_q.ticks_per_atom <= cfg_wdata[TPA_W-1:0];
				default: ;
			endcase
		end
	end

	mtef_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.full(full),
		.atom_time(atom_time),
		.status_byte(status_byte),
		.data_one(data_one),
		.data_two(data_two),
		.event_length(event_length),
		.to_file(to_file),
		.frame_valid(fr_valid),
		.frame(fr_frame),
		.frame_ready(fr_ready)
	);

	mtef_frame_q u_fq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fr_valid),
		.wr_ready(fr_ready),
		.wr_frame(fr_frame),
		.rd_valid(hd_valid),
		.rd_pop(hd_pop),
		.rd_frame(hd_frame)
	);

	mtef_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(hd_valid),
		.frame(hd_frame),
		.frame_pop(hd_pop),
		.empty(empty),
		.pop(pop),
		.result(res)
	);

	assign out_channel = res.channel;
	assign out_byte = res.data;
	assign track_count = res.count;
	assign last_byte = res.last;

endmodule

FILE: rtl/mtef_checker.sv
// Port-level checks for the MIDI track event framer, bound to the top level.
// Depends on midi_track_event_framer_top port names.
module mtef_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  logic pop,
	input  logic [3:0] out_channel,
	input  logic [7:0] out_byte,
	input  logic [31:0] track_count,
	input  logic last_byte
);

	// No word shows while in reset
	a_empty_in_reset: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("word visible during reset");

	// A waiting word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(track_count)))
		else $error("waiting word changed");

	// Bytes of one event follow with no gap, same channel, count plus one
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !last_byte) |=> (!empty
		&& out_channel == $past(out_channel)
		&& track_count == $past(track_count) + 32'd1))
		else $error("event bytes broken up");

endmodule

bind midi_track_event_framer_top mtef_checker u_mtef_checker (.*);
